FILE: hw/rtl/dqvd_pkg.sv
package dqvd_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W = 3;
    localparam int ST_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;
    localparam logic [OP_W-1:0] OP_DUMP       = 3'd6;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic ins_front;
        logic ins_back;
        logic rem_front;
        logic rem_back;
        logic del;
        logic clr;
        logic rotate;
    } t_cell_cmd;

endpackage

FILE: hw/rtl/deque_with_value_delete.sv
// Bounded double-ended queue of signed values, held front to back in a row of cells.
// Input transactions arrive on s_axis: tuser carries the operation code and tdata
// the value to push or to find and delete. Results leave on m_axis: tdata carries
// the status, the entry count after the operation and the dumped entry value;
// tuser flags a dumped entry, and tlast marks the final result of an operation.
// Every operation but dump gives one result, registered in the cycle after its input
// transaction, so such operations can follow back to back while results are taken.
// A dump of a non-empty queue gives one result per entry, front to back, while the
// cells rotate by one position per result. Its first result is loaded only after the
// state register has entered the dump state, and no input transaction is accepted
// until its last result is loaded.
// The single output register lets a new input be accepted while it is being drained.
// When the receiver stalls, the output register holds its result and s_axis_tready
// drops until that result is taken.
// Reset is synchronous and active low; it empties the queue and drops the output
// valid. There is no clearing pass: the block accepts input as soon as reset is released.
module deque_with_value_delete #(
    parameter int DEPTH      = dqvd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dqvd_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // value
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // operation
    input  logic [dqvd_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // status, entry_count, item_value
    output logic [((dqvd_pkg::ST_W+$clog2(DEPTH+1)+DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // item_valid
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import dqvd_pkg::*;

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OD_BITS = ST_W + CNT_W + DATA_WIDTH;
    localparam int OD_W    = ((OD_BITS + 7) / 8) * 8;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                  r_state;
    logic                  n_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      n_idx;

    logic                  r_ovalid;
    logic [ST_W-1:0]       r_ostatus;
    logic [CNT_W-1:0]      r_ocount;
    logic [DATA_WIDTH-1:0] r_oitem;
    logic                  r_oitem_valid;
    logic                  r_olast;

    logic                  w_out_free;
    logic                  w_in_fire;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_load;
    logic [ST_W-1:0]       w_status;
    logic [DATA_WIDTH-1:0] w_item;
    logic                  w_item_valid;
    logic                  w_last;
    logic [DATA_WIDTH-1:0] w_in_value;
    t_cell_cmd             w_cmd;

    logic [DATA_WIDTH-1:0] w_value [DEPTH];
    logic [DEPTH-1:0]      w_valid;
    logic [DEPTH:0]        w_hit;

    assign w_in_value    = s_axis_tdata[DATA_WIDTH-1:0];
    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(DEPTH));
    assign w_empty       = (r_count == '0);
    assign w_hit[0]      = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left_value;
        logic                  w_left_valid;
        logic [DATA_WIDTH-1:0] w_right_value;
        logic                  w_right_valid;

        if (g == 0) begin : g_first
            assign w_left_value = w_in_value;
            assign w_left_valid = 1'b1;
        end else begin : g_inner_l
            assign w_left_value = w_value[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign w_right_value = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner_r
            assign w_right_value = w_value[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        dqvd_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_data        (w_in_value),
            .i_front_value (w_value[0]),
            .i_left_value  (w_left_value),
            .i_left_valid  (w_left_valid),
            .i_right_value (w_right_value),
            .i_right_valid (w_right_valid),
            .i_hit         (w_hit[g]),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_hit         (w_hit[g+1])
        );
    end

    always_comb begin
        w_cmd        = '0;
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        w_load       = 1'b0;
        w_status     = ST_OK;
        w_item       = '0;
        w_item_valid = 1'b0;
        w_last       = 1'b1;
        if (r_state == S_IDLE) begin
            if (w_in_fire) begin
                w_load = 1'b1;
                unique case (s_axis_tuser)
                    OP_PUSH_FRONT: begin
                        if (w_full) begin
                            w_status = ST_FULL;
                        end else begin
                            w_cmd.ins_front = 1'b1;
                            n_count         = r_count + CNT_W'(1);
                        end
                    end
                    OP_PUSH_BACK: begin
                        if (w_full) begin
                            w_status = ST_FULL;
                        end else begin
                            w_cmd.ins_back = 1'b1;
                            n_count        = r_count + CNT_W'(1);
                        end
                    end
                    OP_POP_FRONT: begin
                        if (w_empty) begin
                            w_status = ST_EMPTY;
                        end else begin
                            w_cmd.rem_front = 1'b1;
                            n_count         = r_count - CNT_W'(1);
                        end
                    end
                    OP_POP_BACK: begin
                        if (w_empty) begin
                            w_status = ST_EMPTY;
                        end else begin
                            w_cmd.rem_back = 1'b1;
                            n_count        = r_count - CNT_W'(1);
                        end
                    end
                    OP_DELETE: begin
                        if (w_empty) begin
                            w_status = ST_EMPTY;
                        end else begin
                            w_cmd.del = 1'b1;
                            if (w_hit[DEPTH]) begin
                                n_count = r_count - CNT_W'(1);
                            end else begin
                                w_status = ST_NOT_FOUND;
                            end
                        end
                    end
                    OP_CLEAR: begin
                        if (w_empty) begin
                            w_status = ST_EMPTY;
                        end else begin
                            w_cmd.clr = 1'b1;
                            n_count   = '0;
                        end
                    end
                    OP_DUMP: begin
                        if (w_empty) begin
                            w_status = ST_EMPTY;
                        end else begin
                            w_load  = 1'b0;
                            n_state = S_DUMP;
                            n_idx   = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else begin
            if (w_out_free) begin
                w_load       = 1'b1;
                w_cmd.rotate = 1'b1;
                w_item       = w_value[0];
                w_item_valid = 1'b1;
                w_last       = (r_idx == r_count - CNT_W'(1));
                n_idx        = r_idx + CNT_W'(1);
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ostatus     <= w_status;
            r_ocount      <= n_count;
            r_oitem       <= w_item;
            r_oitem_valid <= w_item_valid;
            r_olast       <= w_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OD_W'({r_oitem, r_ocount, r_ostatus});
    assign m_axis_tuser  = r_oitem_valid;
    assign m_axis_tlast  = r_olast;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell valid bits disagree with entry count");

    a_dump_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DUMP |-> !s_axis_tready)
        else $error("input accepted during dump");

    a_dump_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DUMP |-> r_idx < r_count)
        else $error("dump index beyond held entries");

    a_item_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_oitem_valid |-> r_ostatus == ST_OK)
        else $error("dumped entry with status other than ok");

endmodule

FILE: hw/rtl/dqvd_cell.sv
module dqvd_cell #(
    parameter int DATA_WIDTH = dqvd_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dqvd_pkg::t_cell_cmd   i_cmd,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic [DATA_WIDTH-1:0] i_front_value,
    input  logic [DATA_WIDTH-1:0] i_left_value,
    input  logic                  i_left_valid,
    input  logic [DATA_WIDTH-1:0] i_right_value,
    input  logic                  i_right_valid,
    input  logic                  i_hit,
    output logic [DATA_WIDTH-1:0] o_value,
    output logic                  o_valid,
    output logic                  o_hit
);
    import dqvd_pkg::*;

    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] n_value;
    logic                  r_valid;
    logic                  n_valid;
    logic                  w_match;
    logic                  w_tail;

    assign w_match = r_valid && (r_value == i_data);
    assign o_hit   = i_hit | w_match;
    assign w_tail  = r_valid && !i_right_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_cmd.ins_front) begin
            n_value = i_left_value;
            n_valid = i_left_valid;
        end else if (i_cmd.ins_back) begin
            if (!r_valid && i_left_valid) begin
                n_value = i_data;
                n_valid = 1'b1;
            end
        end else if (i_cmd.rem_front) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_cmd.rem_back) begin
            n_valid = i_right_valid;
        end else if (i_cmd.del) begin
            if (o_hit) begin
                n_value = i_right_value;
                n_valid = i_right_valid;
            end
        end else if (i_cmd.clr) begin
            n_valid = 1'b0;
        end else if (i_cmd.rotate) begin
            if (w_tail) begin
                n_value = i_front_value;
            end else if (r_valid) begin
                n_value = i_right_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

FILE: test/deque_with_value_delete_tb.sv
module deque_with_value_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dqvd_pkg::*;

    localparam int DATA_W = DATA_WIDTH_DEF;
    localparam int CNT_W = $clog2(DEPTH_DEF + 1);
    localparam int S_W = ((DATA_W + 7) / 8) * 8;
    localparam int M_W = ((ST_W + CNT_W + DATA_W + 7) / 8) * 8;
    localparam logic [OP_W-1:0] OP_IGNORED = 3'd7;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int PHASES = 12;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] value;
        logic              item_valid;
        logic              last;
    } t_dq_result;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY} t_op_mix;

    class t_dq_scoreboard;
        logic [DATA_W-1:0] held[$];
        t_dq_result        awaited[$];
        int                errors;

        function new();
            errors = 0;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void add_result(logic [ST_W-1:0] st, logic [DATA_W-1:0] v, logic iv, logic lst);
            t_dq_result r;
            r.status = st;
            r.count = CNT_W'(held.size());
            r.value = v;
            r.item_valid = iv;
            r.last = lst;
            awaited.insert(awaited.size(), r);
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [DATA_W-1:0] v);
            logic [ST_W-1:0] st;
            int              hit;
            st = ST_OK;
            hit = -1;
            case (op)
                OP_PUSH_FRONT: begin
                    if (held.size() >= DEPTH_DEF) st = ST_FULL;
                    else held.insert(0, v);
                end
                OP_PUSH_BACK: begin
                    if (held.size() >= DEPTH_DEF) st = ST_FULL;
                    else held.insert(held.size(), v);
                end
                OP_POP_FRONT: begin
                    if (held.size() == 0) st = ST_EMPTY;
                    else held.delete(0);
                end
                OP_POP_BACK: begin
                    if (held.size() == 0) st = ST_EMPTY;
                    else held.delete(held.size() - 1);
                end
                OP_DELETE: begin
                    if (held.size() == 0) begin
                        st = ST_EMPTY;
                    end else begin
                        foreach (held[i]) if (hit < 0 && held[i] == v) hit = i;
                        if (hit >= 0) held.delete(hit);
                        else st = ST_NOT_FOUND;
                    end
                end
                OP_CLEAR: begin
                    if (held.size() == 0) st = ST_EMPTY;
                    else held.delete();
                end
                OP_DUMP: begin
                    if (held.size() == 0) begin
                        add_result(ST_EMPTY, '0, 1'b0, 1'b1);
                    end else begin
                        foreach (held[i])
                            add_result(ST_OK, held[i], 1'b1, i == held.size() - 1);
                    end
                    return;
                end
                default: ;
            endcase
            add_result(st, '0, 1'b0, 1'b1);
        endfunction

        function void check_result(logic [M_W-1:0] data, logic iv, logic lst);
            t_dq_result want;
            if (awaited.size() == 0) begin
                $error("result with no transaction outstanding: tdata %h", data);
                errors++;
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            if (data[ST_W-1:0] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, data[ST_W-1:0]);
                errors++;
            end
            if (data[ST_W +: CNT_W] !== want.count) begin
                $error("entry_count: expected %0d, got %0d", want.count, data[ST_W +: CNT_W]);
                errors++;
            end
            if (data[ST_W+CNT_W +: DATA_W] !== want.value) begin
                $error("item_value: expected %h, got %h", want.value,
                       data[ST_W+CNT_W +: DATA_W]);
                errors++;
            end
            if (iv !== want.item_valid) begin
                $error("item_valid: expected %0d, got %0d", want.item_valid, iv);
                errors++;
            end
            if (lst !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [S_W-1:0]  s_axis_tdata = '0;   // value
    logic [OP_W-1:0] s_axis_tuser = '0;   // operation
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [M_W-1:0]  m_axis_tdata;        // status, entry_count, item_value
    logic            m_axis_tuser;        // item_valid
    logic            m_axis_tlast;

    t_dq_scoreboard sb = new();
    int             cycles = 0;
    int             rx_hold = 0;
    int             rx_mode_left = 0;
    bit             rx_steady = 1'b0;

    deque_with_value_delete #(
        .DEPTH(DEPTH_DEF),
        .DATA_WIDTH(DATA_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OP_W-1:0] pick_op(t_op_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (r < 35) return OP_PUSH_FRONT;
                if (r < 70) return OP_PUSH_BACK;
                if (r < 78) return OP_POP_FRONT;
                if (r < 84) return OP_POP_BACK;
                if (r < 90) return OP_DELETE;
                if (r < 96) return OP_DUMP;
                if (r < 98) return OP_CLEAR;
            end
            MIX_DRAIN: begin
                if (r < 10) return OP_PUSH_FRONT;
                if (r < 20) return OP_PUSH_BACK;
                if (r < 42) return OP_POP_FRONT;
                if (r < 64) return OP_POP_BACK;
                if (r < 86) return OP_DELETE;
                if (r < 94) return OP_DUMP;
                if (r < 97) return OP_CLEAR;
            end
            default: begin
                if (r < 20) return OP_PUSH_FRONT;
                if (r < 40) return OP_PUSH_BACK;
                if (r < 52) return OP_POP_FRONT;
                if (r < 64) return OP_POP_BACK;
                if (r < 80) return OP_DELETE;
                if (r < 92) return OP_DUMP;
                if (r < 96) return OP_CLEAR;
            end
        endcase
        return OP_IGNORED;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(logic [OP_W-1:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (op == OP_DELETE && sb.held.size() != 0 && r < 65)
            return sb.held[$urandom_range(0, sb.held.size() - 1)];
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom;
        if (r < 80) return DATA_W'(int'($urandom_range(0, 7)) - 4);
        if (r < 90) return r[0] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        return r[0] ? '1 : '0;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v,
                             input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, v);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (rx_mode_left == 0) begin
            rx_steady = ($urandom_range(0, 3) == 0);
            rx_mode_left = $urandom_range(50, 300);
        end else begin
            rx_mode_left--;
        end
        if (rx_steady) begin
            m_axis_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            rx_hold = gap_len();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("deque_with_value_delete_tb: FAIL");
            $finish;
        end
    end

    initial begin
        t_op_mix         mix;
        bit              tx_steady;
        logic [OP_W-1:0] op;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Everything on an empty queue, then extremes, duplicates and misses.
        send_item(OP_DUMP, '0, gap_len());
        send_item(OP_POP_FRONT, '0, gap_len());
        send_item(OP_POP_BACK, '1, gap_len());
        send_item(OP_DELETE, 32'd5, gap_len());
        send_item(OP_CLEAR, '0, gap_len());
        send_item(OP_IGNORED, '1, gap_len());
        send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF, gap_len());
        send_item(OP_PUSH_FRONT, 32'h8000_0000, gap_len());
        send_item(OP_PUSH_BACK, 32'h0000_0000, gap_len());
        send_item(OP_PUSH_BACK, 32'hFFFF_FFFF, gap_len());
        send_item(OP_PUSH_BACK, 32'h8000_0000, gap_len());
        send_item(OP_DUMP, '0, gap_len());
        send_item(OP_DELETE, 32'h8000_0000, gap_len());
        send_item(OP_DELETE, 32'd12345, gap_len());
        send_item(OP_IGNORED, 32'h5A5A_A5A5, gap_len());
        send_item(OP_POP_FRONT, '0, gap_len());
        send_item(OP_POP_BACK, '0, gap_len());
        send_item(OP_DUMP, '0, gap_len());
        send_item(OP_CLEAR, '0, gap_len());
        send_item(OP_DUMP, '0, gap_len());

        for (int p = 0; p < PHASES; p++) begin
            mix = (p == 0) ? MIX_FILL : t_op_mix'($urandom_range(0, 2));
            tx_steady = ($urandom_range(0, 3) == 0);
            if (p == PHASES / 2 || $urandom_range(0, 2) == 0)
                wait_drained();
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                op = pick_op(mix);
                send_item(op, pick_value(op), tx_steady ? 0 : gap_len());
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("deque_with_value_delete_tb: PASS");
        else
            $display("deque_with_value_delete_tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/dqvd_pkg.sv
hw/rtl/dqvd_cell.sv
hw/rtl/deque_with_value_delete.sv
test/deque_with_value_delete_tb.sv
